// ----- design/ils_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store: operation and status
// codes, controller states, and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_READ   = 2'd1,
    MODE_SWAP   = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BOUNDS = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_DATA,
    ST_SWAP_B,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_REM_CAP,
    ST_REM_SHIFT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RADDR_A,
    RADDR_B,
    RADDR_A_PLUS1,
    RADDR_PTR_PLUS2
  } raddr_sel_e;

  typedef enum logic [1:0] {
    WADDR_COUNT,
    WADDR_A,
    WADDR_B,
    WADDR_PTR
  } waddr_sel_e;

  typedef enum logic [1:0] {
    WDATA_ITEM,
    WDATA_RDATA,
    WDATA_TMP
  } wdata_sel_e;

  typedef enum logic {
    ITEM_ZERO,
    ITEM_RDATA
  } item_sel_e;

  typedef struct packed {
    logic       load_in;
    raddr_sel_e raddr_sel;
    logic       ram_we;
    waddr_sel_e waddr_sel;
    wdata_sel_e wdata_sel;
    logic       ptr_load;
    logic       ptr_inc;
    logic       tmp_capture;
    logic       count_inc;
    logic       count_dec;
    logic       res_set;
    status_e    res_status;
    item_sel_e  res_item_sel;
    logic       out_load;
  } ils_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  a_oob;
    logic  b_oob;
    logic  a1_last;
    logic  p2_last;
    logic  out_free;
  } ils_stat_t;

endpackage

// ----- design/indexed_list_store.sv -----
`timescale 1ns / 1ps
// One operation is in flight at a time: a new input is accepted only after the
// previous result has been loaded into the output register. Remove shifts one
// word per cycle through the single read and write port of the entry RAM. Reset
// clears the count and the output valid; entry contents are undefined until
// written.
// ----------------------------------------------------------------------------
// indexed_list_store
// Fixed-depth ordered list of data words with append, read, swap and remove
// operations, built from a controller and a datapath around one entry RAM.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // index_a[5:0], index_b[11:6], item_value[43:12]
  input  logic [1:0]  s_axis_tuser_i,  // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // item_out[31:0], count_out[37:32]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  ils_pkg::ils_cmd_t  cmd;
  ils_pkg::ils_stat_t stat;
  logic [31:0]        item_out;
  logic [5:0]         count_out;

  ils_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ils_dp #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (s_axis_tuser_i),
    .index_a_i   (s_axis_tdata_i[5:0]),
    .index_b_i   (s_axis_tdata_i[11:6]),
    .item_value_i(s_axis_tdata_i[43:12]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .status_o    (m_axis_tuser_o),
    .item_out_o  (item_out),
    .count_out_o (count_out),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign m_axis_tdata_o = {2'b00, count_out, item_out};

endmodule

// ----- design/ils_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ils_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_ctrl
// Controller for the indexed list store. Sequences each operation through the
// datapath and the entry RAM, one RAM access per port per cycle.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ils_pkg::ils_stat_t stat_i,
  output ils_pkg::ils_cmd_t  cmd_o
);

  ils_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ils_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    cmd_o.raddr_sel    = ils_pkg::RADDR_A;
    cmd_o.waddr_sel    = ils_pkg::WADDR_COUNT;
    cmd_o.wdata_sel    = ils_pkg::WDATA_ITEM;
    cmd_o.res_status   = ils_pkg::STAT_OK;
    cmd_o.res_item_sel = ils_pkg::ITEM_ZERO;
    case (state_q)
      ils_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ils_pkg::ST_DECODE;
        end
      end
      ils_pkg::ST_DECODE: begin
        case (stat_i.mode)
          ils_pkg::MODE_APPEND: begin
            cmd_o.res_set = 1'b1;
            if (stat_i.full) begin
              cmd_o.res_status = ils_pkg::STAT_FULL;
            end else begin
              cmd_o.ram_we    = 1'b1;
              cmd_o.waddr_sel = ils_pkg::WADDR_COUNT;
              cmd_o.wdata_sel = ils_pkg::WDATA_ITEM;
              cmd_o.count_inc = 1'b1;
            end
            state_d = ils_pkg::ST_DONE;
          end
          ils_pkg::MODE_READ: begin
            if (stat_i.a_oob) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ils_pkg::STAT_BOUNDS;
              state_d          = ils_pkg::ST_DONE;
            end else begin
              cmd_o.raddr_sel = ils_pkg::RADDR_A;
              state_d         = ils_pkg::ST_RD_DATA;
            end
          end
          ils_pkg::MODE_SWAP: begin
            if (stat_i.a_oob || stat_i.b_oob) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ils_pkg::STAT_BOUNDS;
              state_d          = ils_pkg::ST_DONE;
            end else begin
              cmd_o.raddr_sel = ils_pkg::RADDR_A;
              state_d         = ils_pkg::ST_SWAP_B;
            end
          end
          default: begin
            if (stat_i.a_oob) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ils_pkg::STAT_BOUNDS;
              state_d          = ils_pkg::ST_DONE;
            end else begin
              cmd_o.raddr_sel = ils_pkg::RADDR_A;
              cmd_o.ptr_load  = 1'b1;
              state_d         = ils_pkg::ST_REM_CAP;
            end
          end
        endcase
      end
      ils_pkg::ST_RD_DATA: begin
        cmd_o.res_set      = 1'b1;
        cmd_o.res_item_sel = ils_pkg::ITEM_RDATA;
        state_d            = ils_pkg::ST_DONE;
      end
      ils_pkg::ST_SWAP_B: begin
        cmd_o.raddr_sel   = ils_pkg::RADDR_B;
        cmd_o.tmp_capture = 1'b1;
        state_d           = ils_pkg::ST_SWAP_WA;
      end
      ils_pkg::ST_SWAP_WA: begin
        cmd_o.ram_we    = 1'b1;
        cmd_o.waddr_sel = ils_pkg::WADDR_A;
        cmd_o.wdata_sel = ils_pkg::WDATA_RDATA;
        state_d         = ils_pkg::ST_SWAP_WB;
      end
      ils_pkg::ST_SWAP_WB: begin
        cmd_o.ram_we    = 1'b1;
        cmd_o.waddr_sel = ils_pkg::WADDR_B;
        cmd_o.wdata_sel = ils_pkg::WDATA_TMP;
        cmd_o.res_set   = 1'b1;
        state_d         = ils_pkg::ST_DONE;
      end
      ils_pkg::ST_REM_CAP: begin
        cmd_o.res_set      = 1'b1;
        cmd_o.res_item_sel = ils_pkg::ITEM_RDATA;
        if (stat_i.a1_last) begin
          cmd_o.count_dec = 1'b1;
          state_d         = ils_pkg::ST_DONE;
        end else begin
          cmd_o.raddr_sel = ils_pkg::RADDR_A_PLUS1;
          state_d         = ils_pkg::ST_REM_SHIFT;
        end
      end
      ils_pkg::ST_REM_SHIFT: begin
        cmd_o.ram_we    = 1'b1;
        cmd_o.waddr_sel = ils_pkg::WADDR_PTR;
        cmd_o.wdata_sel = ils_pkg::WDATA_RDATA;
        cmd_o.ptr_inc   = 1'b1;
        if (stat_i.p2_last) begin
          cmd_o.count_dec = 1'b1;
          state_d         = ils_pkg::ST_DONE;
        end else begin
          cmd_o.raddr_sel = ils_pkg::RADDR_PTR_PLUS2;
        end
      end
      ils_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ils_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ils_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/ils_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_dp
// Datapath for the indexed list store: the captured request, the live count,
// the shift pointer, the entry RAM and the result register.
// ----------------------------------------------------------------------------
module ils_dp #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         mode_i,
  input  logic [5:0]         index_a_i,
  input  logic [5:0]         index_b_i,
  input  logic [31:0]        item_value_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [31:0]        item_out_o,
  output logic [5:0]         count_out_o,
  input  ils_pkg::ils_cmd_t  cmd_i,
  output ils_pkg::ils_stat_t stat_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int EW = ((CW > 6) ? CW : 6) + 1;

  ils_pkg::mode_e    mode_q;
  logic [5:0]        ia_q;
  logic [5:0]        ib_q;
  logic [31:0]       item_q;
  logic [CW-1:0]     count_q;
  logic [AW-1:0]     ptr_q;
  logic [DATA_WIDTH-1:0] tmp_q;
  ils_pkg::status_e  res_status_q;
  logic [31:0]       res_item_q;
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [31:0]       out_item_q;
  logic [5:0]        out_count_q;

  logic [EW-1:0]     cnt_x;
  logic [EW-1:0]     ia_x;
  logic [EW-1:0]     ib_x;
  logic [EW-1:0]     ia1_x;
  logic [EW-1:0]     ptr2_x;
  logic [63:0]       item_ext;
  logic [63:0]       rd_ext;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;

  assign cnt_x    = EW'(count_q);
  assign ia_x     = EW'(ia_q);
  assign ib_x     = EW'(ib_q);
  assign ia1_x    = ia_x + EW'(1);
  assign ptr2_x   = EW'(ptr_q) + EW'(2);
  assign item_ext = {32'd0, item_q};

  always_comb begin
    rd_ext                   = '0;
    rd_ext[DATA_WIDTH-1:0]   = rdata;
  end

  always_comb begin
    case (cmd_i.raddr_sel)
      ils_pkg::RADDR_A:         raddr = ia_x[AW-1:0];
      ils_pkg::RADDR_B:         raddr = ib_x[AW-1:0];
      ils_pkg::RADDR_A_PLUS1:   raddr = ia1_x[AW-1:0];
      ils_pkg::RADDR_PTR_PLUS2: raddr = ptr2_x[AW-1:0];
      default:                  raddr = ia_x[AW-1:0];
    endcase
    case (cmd_i.waddr_sel)
      ils_pkg::WADDR_COUNT: waddr = count_q[AW-1:0];
      ils_pkg::WADDR_A:     waddr = ia_x[AW-1:0];
      ils_pkg::WADDR_B:     waddr = ib_x[AW-1:0];
      ils_pkg::WADDR_PTR:   waddr = ptr_q;
      default:              waddr = ptr_q;
    endcase
    case (cmd_i.wdata_sel)
      ils_pkg::WDATA_ITEM:  wdata = item_ext[DATA_WIDTH-1:0];
      ils_pkg::WDATA_RDATA: wdata = rdata;
      ils_pkg::WDATA_TMP:   wdata = tmp_q;
      default:              wdata = rdata;
    endcase
  end

  ils_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= ils_pkg::mode_e'(mode_i);
      ia_q   <= index_a_i;
      ib_q   <= index_b_i;
      item_q <= item_value_i;
    end
    if (cmd_i.ptr_load) begin
      ptr_q <= ia_x[AW-1:0];
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + AW'(1);
    end
    if (cmd_i.tmp_capture) begin
      tmp_q <= rdata;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_item_q   <= (cmd_i.res_item_sel == ils_pkg::ITEM_RDATA) ? rd_ext[31:0] : 32'd0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_item_q   <= res_item_q;
      out_count_q  <= cnt_x[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.mode     = mode_q;
  assign stat_o.full     = (cnt_x == EW'(DEPTH));
  assign stat_o.a_oob    = (ia_x >= cnt_x);
  assign stat_o.b_oob    = (ib_x >= cnt_x);
  assign stat_o.a1_last  = (ia1_x >= cnt_x);
  assign stat_o.p2_last  = (ptr2_x >= cnt_x);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign item_out_o  = out_item_q;
  assign count_out_o = out_count_q;

`ifndef ASSERT_OFF
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= EW'(DEPTH))
    else $error("entry count exceeds depth");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_append_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_inc |-> (cnt_x < EW'(DEPTH)) && cmd_i.ram_we)
    else $error("append into a full list");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_dec |=> (count_q == $past(count_q) - CW'(1)))
    else $error("remove did not lower the count by one");
`endif

endmodule

// ----- bench/tb_indexed_list_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store
// Self-checking bench for the indexed list store. A directed sequence covers
// the empty list, extreme words, every operation and the bounds, full and
// self-swap cases. Random phases then grow, shrink and mix the list with
// random idle on both stream sides, and end with a stretch at full rate.
// Every result transfer is checked field by field against an internal
// prediction of the list contents and count.
// ----------------------------------------------------------------------------
module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int LIST_DEPTH = 32;

  typedef struct packed {
    status_e     status;
    logic [31:0] word;
    logic [5:0]  count;
  } list_result_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;   // index_a[5:0], index_b[11:6], item_value[43:12]
  logic [1:0]  s_axis_tuser_i = '0;   // mode[1:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // item_out[31:0], count_out[37:32]
  logic [1:0]  m_axis_tuser_o;        // status[1:0]

  logic [31:0]  model_words [LIST_DEPTH];
  int           model_count;
  list_result_t pending_results [$];

  bit sender_gaps_on;
  bit sink_stalls_on;
  int stall_left;
  int error_count;
  int op_tally [4];
  int full_hits;
  int bounds_hits;
  int peak_count;

  indexed_list_store #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (32)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic list_result_t list_apply_op(input mode_e op, input logic [5:0] ia,
                                                 input logic [5:0] ib,
                                                 input logic [31:0] word);
    list_result_t res;
    logic [31:0]  held;
    res.status = STAT_OK;
    res.word   = '0;
    op_tally[op]++;
    case (op)
      MODE_APPEND: begin
        if (model_count >= LIST_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          model_words[model_count] = word;
          model_count++;
        end
      end
      MODE_READ: begin
        if (ia >= model_count) res.status = STAT_BOUNDS;
        else res.word = model_words[ia];
      end
      MODE_SWAP: begin
        if (ia >= model_count || ib >= model_count) begin
          res.status = STAT_BOUNDS;
        end else begin
          held            = model_words[ia];
          model_words[ia] = model_words[ib];
          model_words[ib] = held;
        end
      end
      default: begin
        if (ia >= model_count) begin
          res.status = STAT_BOUNDS;
        end else begin
          res.word = model_words[ia];
          for (int i = ia; i + 1 < model_count; i++) model_words[i] = model_words[i + 1];
          model_count--;
        end
      end
    endcase
    if (res.status == STAT_FULL) full_hits++;
    if (res.status == STAT_BOUNDS) bounds_hits++;
    if (model_count > peak_count) peak_count = model_count;
    res.count = model_count[5:0];
    return res;
  endfunction

  function automatic logic [5:0] pick_index();
    if (model_count > 0 && $urandom_range(0, 4) != 0) begin
      return 6'($urandom_range(0, model_count - 1));
    end
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic send_op(input mode_e op, input logic [5:0] ia, input logic [5:0] ib,
                         input logic [31:0] word);
    int gap;
    if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0000, word, ib, ia};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(list_apply_op(op, ia, ib, word));
  endtask

  task automatic send_random_op(input int w_app, input int w_rd, input int w_sw, input int w_rm);
    int    roll;
    mode_e op;
    roll = $urandom_range(0, w_app + w_rd + w_sw + w_rm - 1);
    if (roll < w_app) op = MODE_APPEND;
    else if (roll < w_app + w_rd) op = MODE_READ;
    else if (roll < w_app + w_rd + w_sw) op = MODE_SWAP;
    else op = MODE_REMOVE;
    send_op(op, pick_index(), pick_index(), $urandom());
  endtask

  // Sink side: random stall bursts while enabled, otherwise always ready.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected: status %0d word %h count %0d",
                 $time, m_axis_tuser_o, m_axis_tdata_o[31:0], m_axis_tdata_o[37:32]);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tuser_o !== exp_res.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, exp_res.status, m_axis_tuser_o);
          error_count++;
        end
        if (m_axis_tdata_o[31:0] !== exp_res.word) begin
          $display("%0t: item_out mismatch: expected %h, actual %h",
                   $time, exp_res.word, m_axis_tdata_o[31:0]);
          error_count++;
        end
        if (m_axis_tdata_o[37:32] !== exp_res.count) begin
          $display("%0t: count_out mismatch: expected %0d, actual %0d",
                   $time, exp_res.count, m_axis_tdata_o[37:32]);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_op(MODE_READ, 6'd0, 6'd0, 32'h0);
    send_op(MODE_REMOVE, 6'd0, 6'd0, 32'h0);
    send_op(MODE_SWAP, 6'd0, 6'd0, 32'h0);
  endtask

  task automatic test_append_extremes();
    send_op(MODE_APPEND, 6'd63, 6'd63, 32'h0000_0000);
    send_op(MODE_APPEND, 6'd0, 6'd0, 32'hFFFF_FFFF);
    send_op(MODE_APPEND, 6'd21, 6'd42, 32'hAAAA_AAAA);
    send_op(MODE_APPEND, 6'd42, 6'd21, 32'h5555_5555);
    send_op(MODE_APPEND, 6'd1, 6'd2, 32'h0000_0001);
  endtask

  task automatic test_read_bounds();
    send_op(MODE_READ, 6'd0, 6'd63, 32'hFFFF_FFFF);
    send_op(MODE_READ, 6'd4, 6'd0, 32'h0);
    send_op(MODE_READ, 6'd5, 6'd0, 32'h0);
    send_op(MODE_READ, 6'd63, 6'd0, 32'h0);
  endtask

  task automatic test_swap();
    send_op(MODE_SWAP, 6'd1, 6'd1, 32'h0);
    send_op(MODE_SWAP, 6'd0, 6'd4, 32'hFFFF_FFFF);
    send_op(MODE_SWAP, 6'd2, 6'd5, 32'h0);
    send_op(MODE_SWAP, 6'd63, 6'd0, 32'h0);
    send_op(MODE_READ, 6'd0, 6'd0, 32'h0);
  endtask

  task automatic test_remove();
    send_op(MODE_REMOVE, 6'd4, 6'd0, 32'h0);
    send_op(MODE_REMOVE, 6'd0, 6'd0, 32'h0);
    send_op(MODE_REMOVE, 6'd1, 6'd0, 32'h0);
    send_op(MODE_REMOVE, 6'd2, 6'd0, 32'h0);
    send_op(MODE_READ, 6'd1, 6'd0, 32'h0);
  endtask

  task automatic test_fill_to_full();
    while (model_count < LIST_DEPTH) send_op(MODE_APPEND, pick_index(), pick_index(), $urandom());
    repeat (3) send_op(MODE_APPEND, pick_index(), pick_index(), $urandom());
    repeat (10) send_random_op(0, 1, 1, 0);
    send_op(MODE_READ, 6'(LIST_DEPTH - 1), 6'd0, 32'h0);
    send_op(MODE_SWAP, 6'd0, 6'(LIST_DEPTH - 1), 32'h0);
    send_op(MODE_REMOVE, 6'd0, 6'd0, 32'h0);
    send_op(MODE_APPEND, 6'd0, 6'd0, $urandom());
  endtask

  task automatic test_drain_to_empty();
    while (model_count > 0) begin
      send_op(MODE_REMOVE, 6'($urandom_range(0, model_count - 1)), pick_index(), $urandom());
    end
    send_op(MODE_REMOVE, 6'd0, 6'd0, 32'h0);
    send_op(MODE_READ, 6'd0, 6'd0, 32'h0);
  endtask

  // Phases lean toward growth, shrinkage or an even mix so the count sweeps the
  // whole range, including a full list and an empty one.
  task automatic test_random_mix(input int phases);
    int kind;
    for (int p = 0; p < phases; p++) begin
      kind = $urandom_range(0, 2);
      repeat (50) begin
        case (kind)
          0:       send_random_op(70, 10, 10, 10);
          1:       send_random_op(10, 15, 15, 60);
          default: send_random_op(25, 25, 25, 25);
        endcase
      end
    end
  endtask

  initial begin
    model_count = 0;
    peak_count  = 0;
    error_count = 0;
    full_hits   = 0;
    bounds_hits = 0;
    stall_left  = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_append_extremes();
    test_read_bounds();
    test_swap();
    test_remove();

    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    test_fill_to_full();
    test_drain_to_empty();
    test_random_mix(14);
    test_fill_to_full();

    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    test_drain_to_empty();
    test_random_mix(2);

    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LIST_DEPTH + 16) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      error_count++;
    end

    $display("Sent %0d appends, %0d reads, %0d swaps and %0d removes.",
             op_tally[MODE_APPEND], op_tally[MODE_READ], op_tally[MODE_SWAP],
             op_tally[MODE_REMOVE]);
    $display("Saw %0d full and %0d out-of-range results; the list reached %0d entries.",
             full_hits, bounds_hits, peak_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
